// ----- rtl/assert_macros.svh -----
// Shared assertion shorthands; clk and arst_n are taken from the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define SMMA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define SMMA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/smma_pkg.sv -----
package smma_pkg;

	// Sizes of the fields and of the arithmetic
	localparam int MAX_DIM_DEF = 32;
	localparam int DIM_W       = 6;
	localparam int IDX_W       = 10;
	localparam int VAL_W       = 32;
	localparam int AB_W        = 16;
	localparam int C_W         = 32;
	localparam int SCALE_W     = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int PTR_W       = 2 * DIM_W;
	localparam int PROD1_W     = 32;
	localparam int ACC_W       = 48;
	localparam int FRAC_SHIFT  = 8;
	localparam int DIV_STEPS   = IDX_W;
	localparam int DRAIN_CYC   = 3;

	// Register reset values
	localparam logic [DIM_W-1:0]          ROWS_RST  = 6'd32;
	localparam logic [DIM_W-1:0]          INNER_RST = 6'd32;
	localparam logic [DIM_W-1:0]          COLS_RST  = 6'd32;
	localparam logic signed [SCALE_W-1:0] ALPHA_RST = 16'sd256;
	localparam logic signed [SCALE_W-1:0] BETA_RST  = 16'sd0;

	// Saturation bounds
	localparam logic signed [VAL_W-1:0] AB_MAX = 32'sh0000_7FFF;
	localparam logic signed [VAL_W-1:0] AB_MIN = -32'sh0000_8000;
	localparam logic signed [C_W-1:0]   C_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [C_W-1:0]   C_MIN  = 32'sh8000_0000;

	typedef enum logic [1:0] {
		FUNC_LOAD_A  = 2'd0,
		FUNC_LOAD_B  = 2'd1,
		FUNC_LOAD_C  = 2'd2,
		FUNC_COMPUTE = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROWS_N  = 3'd0,
		CFG_INNER_M = 3'd1,
		CFG_COLS_K  = 3'd2,
		CFG_ALPHA   = 3'd3,
		CFG_BETA    = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SETUP,
		ST_MAC,
		ST_DRAIN,
		ST_FINISH,
		ST_PUSH
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic start;
		logic div_step;
		logic setup;
		logic mac_issue;
		logic finish;
		logic push;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic             idx_ok;
		logic [DIM_W-1:0] eff_m;
		logic             out_free;
	} sts_t;

	// Clip to 16 bits; the top bit flags clipping
	function automatic logic [AB_W:0] clip_ab(input logic signed [VAL_W-1:0] v);
		logic [AB_W:0] r;
		if (v > AB_MAX) begin
			r = {1'b1, AB_MAX[AB_W-1:0]};
		end else if (v < AB_MIN) begin
			r = {1'b1, AB_MIN[AB_W-1:0]};
		end else begin
			r = {1'b0, v[AB_W-1:0]};
		end
		return r;
	endfunction

	// Zero acts as one, anything above max_dim as max_dim
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r, input int max_dim);
		logic [DIM_W-1:0] d;
		if (r == '0) begin
			d = DIM_W'(1);
		end else if (int'(r) > max_dim) begin
			d = DIM_W'(max_dim);
		end else begin
			d = r;
		end
		return d;
	endfunction

endpackage

// ----- rtl/smma_in_if.sv -----
interface smma_in_if;
	logic                valid;
	logic                ready;
	logic [1:0]          func;
	logic [9:0]          index;
	logic signed [31:0]  value;

	modport source (output valid, output func, output index, output value, input ready);
	modport sink (input valid, input func, input index, input value, output ready);
endinterface

// ----- rtl/smma_out_if.sv -----
interface smma_out_if;
	logic                valid;
	logic                ready;
	logic signed [31:0]  result_value;
	logic                saturated;

	modport source (output valid, output result_value, output saturated, input ready);
	modport sink (input valid, input result_value, input saturated, output ready);
endinterface

// ----- rtl/smma_ctrl.sv -----
module smma_ctrl
	import smma_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic [1:0]           item_func,
	output logic                 item_ready,
	input  sts_t                 sts,
	output cmd_t                 cmd
);

	state_t           state_q, state_d;
	logic [DIM_W-1:0] cnt_q;

	// State register and step counter; the counter restarts on every state change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + DIM_W'(1);
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (item_func == FUNC_COMPUTE) begin
						// drop a compute beat whose index lies outside C
						if (sts.idx_ok) begin
							cmd.start = 1'b1;
							state_d   = ST_DIV;
						end
					end else begin
						cmd.load = 1'b1;
						state_d  = ST_PUSH;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIM_W'(DIV_STEPS - 1)) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_MAC;
			end
			ST_MAC: begin
				cmd.mac_issue = 1'b1;
				if (cnt_q == sts.eff_m - DIM_W'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// wait for the last term to reach the accumulator
				if (cnt_q == DIM_W'(DRAIN_CYC - 1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_PUSH;
			end
			ST_PUSH: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/smma_datapath.sv -----
module smma_datapath
	import smma_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic [1:0]            item_func,
	input  logic [IDX_W-1:0]      item_index,
	input  logic signed [VAL_W-1:0] item_value,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic signed [C_W-1:0] result_value,
	output logic                  result_saturated
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);

	// Configuration registers
	logic [DIM_W-1:0]          rows_q, inner_q, cols_q;
	logic signed [SCALE_W-1:0] alpha_q, beta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= ROWS_RST;
			inner_q <= INNER_RST;
			cols_q  <= COLS_RST;
			alpha_q <= ALPHA_RST;
			beta_q  <= BETA_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ROWS_N:  rows_q  <= cfg_wdata[DIM_W-1:0];
				CFG_INNER_M: inner_q <= cfg_wdata[DIM_W-1:0];
				CFG_COLS_K:  cols_q  <= cfg_wdata[DIM_W-1:0];
				CFG_ALPHA:   alpha_q <= $signed(cfg_wdata);
				CFG_BETA:    beta_q  <= $signed(cfg_wdata);
				default: ;
			endcase
		end
	end

	logic [DIM_W-1:0] n_eff, m_eff, k_eff;
	logic [PTR_W-1:0] nk;
	logic             ld_ok;

	assign n_eff = eff_dim(rows_q, MAX_DIM);
	assign m_eff = eff_dim(inner_q, MAX_DIM);
	assign k_eff = eff_dim(cols_q, MAX_DIM);
	assign nk    = n_eff * k_eff;
	assign ld_ok = int'(item_index) < DEPTH;

	// Clip A and B loads to 16 bits; C loads pass unchanged
	logic [AB_W:0]           ab_clip;
	logic [AB_W-1:0]         ab_val;
	logic                    ld_clip;
	logic signed [C_W-1:0]   ld_stored;

	assign ab_clip   = clip_ab(item_value);
	assign ab_val    = ab_clip[AB_W-1:0];
	assign ld_clip   = (item_func == FUNC_LOAD_C) ? 1'b0 : ab_clip[AB_W];
	assign ld_stored = (item_func == FUNC_LOAD_C) ? item_value
		: {{(C_W-AB_W){ab_val[AB_W-1]}}, ab_val};

	// Compute index, shift-subtract divider for row and column
	logic [IDX_W-1:0] idx_q, quo_q;
	logic [DIM_W-1:0] rem_q;
	logic [DIM_W:0]   trial, trial_sub;
	logic             trial_ge;

	assign trial     = {rem_q, quo_q[IDX_W-1]};
	assign trial_ge  = trial >= {1'b0, k_eff};
	assign trial_sub = trial - {1'b0, k_eff};

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			idx_q <= item_index;
			quo_q <= item_index;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[IDX_W-2:0], trial_ge};
			rem_q <= trial_ge ? trial_sub[DIM_W-1:0] : trial[DIM_W-1:0];
		end
	end

	// Operand pointers: A walks along the row, B steps down the column
	logic [PTR_W-1:0] a_ptr_q, b_ptr_q;

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			a_ptr_q <= quo_q[DIM_W-1:0] * m_eff;
			b_ptr_q <= PTR_W'(rem_q);
		end else if (cmd.mac_issue) begin
			a_ptr_q <= a_ptr_q + PTR_W'(1);
			b_ptr_q <= b_ptr_q + PTR_W'(k_eff);
		end
	end

	// Operand stores
	logic [AB_W-1:0] a_mem [DEPTH];
	logic [AB_W-1:0] b_mem [DEPTH];
	logic [C_W-1:0]  c_mem [DEPTH];

	logic [AB_W-1:0]       a_rd_s1, b_rd_s1;
	logic                  a_ok_s1, b_ok_s1;
	logic signed [C_W-1:0] c_rd_q;
	logic signed [C_W-1:0] sat_val;
	logic                  sat_flag;

	always_ff @(posedge clk) begin
		if (cmd.load && ld_ok && (item_func == FUNC_LOAD_A)) begin
			a_mem[AW'(item_index)] <= ab_val;
		end
		if (cmd.mac_issue) begin
			a_rd_s1 <= a_mem[AW'(a_ptr_q)];
			a_ok_s1 <= int'(a_ptr_q) < DEPTH;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && ld_ok && (item_func == FUNC_LOAD_B)) begin
			b_mem[AW'(item_index)] <= ab_val;
		end
		if (cmd.mac_issue) begin
			b_rd_s1 <= b_mem[AW'(b_ptr_q)];
			b_ok_s1 <= int'(b_ptr_q) < DEPTH;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && ld_ok && (item_func == FUNC_LOAD_C)) begin
			c_mem[AW'(item_index)] <= ld_stored;
		end else if (cmd.finish) begin
			c_mem[AW'(idx_q)] <= sat_val;
		end
		if (cmd.start) begin
			c_rd_q <= c_mem[AW'(item_index)];
		end
	end

	// Multiply pipeline: alpha*A, then times B, then accumulate
	logic                       valid_s1, valid_s2, valid_s3;
	logic signed [AB_W-1:0]     a_op, b_op;
	logic signed [PROD1_W-1:0]  p1_s2;
	logic signed [AB_W-1:0]     b_s2;
	logic signed [ACC_W-1:0]    t_s3;
	logic signed [ACC_W-1:0]    bc;
	logic signed [ACC_W-1:0]    acc_q;

	assign a_op = a_ok_s1 ? $signed(a_rd_s1) : '0;
	assign b_op = b_ok_s1 ? $signed(b_rd_s1) : '0;
	assign bc   = beta_q * c_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= cmd.mac_issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		p1_s2 <= alpha_q * a_op;
		b_s2  <= b_op;
		t_s3  <= p1_s2 * b_s2;
		if (cmd.setup) begin
			acc_q <= bc >>> FRAC_SHIFT;
		end else if (valid_s3) begin
			acc_q <= acc_q + (t_s3 >>> FRAC_SHIFT);
		end
	end

	// Saturate the sum to 32 bits
	logic sat_hi, sat_lo;

	assign sat_hi   = !acc_q[ACC_W-1] && (|acc_q[ACC_W-2:C_W-1]);
	assign sat_lo   = acc_q[ACC_W-1] && !(&acc_q[ACC_W-2:C_W-1]);
	assign sat_flag = sat_hi || sat_lo;
	assign sat_val  = sat_hi ? C_MAX : (sat_lo ? C_MIN : acc_q[C_W-1:0]);

	// Result holding register, then output register
	logic signed [C_W-1:0] res_val_q, out_val_q;
	logic                  res_sat_q, out_sat_q, out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_val_q <= ld_stored;
			res_sat_q <= ld_clip;
		end else if (cmd.finish) begin
			res_val_q <= sat_val;
			res_sat_q <= sat_flag;
		end
		if (cmd.push) begin
			out_val_q <= res_val_q;
			out_sat_q <= res_sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid     = out_valid_q;
	assign result_value     = out_val_q;
	assign result_saturated = out_sat_q;

	assign sts.idx_ok   = PTR_W'(item_index) < nk;
	assign sts.eff_m    = m_eff;
	assign sts.out_free = !out_valid_q || result_ready;

endmodule

// ----- rtl/scaled_matrix_multiply_accumulate.sv -----
// Fixed-point GEMM element engine: C = beta*C + sum(alpha*A*B), row-major.
// Channels: item (func, index, value) in, result (result_value, saturated)
// out, both valid/ready; a beat moves when valid and ready are high at a
// rising edge. Registers are set through cfg_we/cfg_index/cfg_wdata; the user
// must write them only while idle, as the block does not enforce it.
// Load beats (A, B, C) always return one result beat: the value as stored,
// with saturated set when an A or B value clipped to 16 bits. A compute beat
// passes through the accept cycle, the row/column divider, a setup step, one
// inner term per cycle through the shared multiply-accumulate, the pipeline
// drain, saturation and write-back, and the load of the output register,
// which waits while a stalled result still holds it.
// A compute beat whose index lies outside rows_n*cols_k returns nothing.
// Items are taken one at a time; item.ready is high only while idle.
// The output register keeps a finished result while the next item is taken;
// when the receiver stalls the block holds its next result until it drains.
// Reset clears the registers to their defaults and empties the output;
// the stores keep no reset value and must be written before they are read.
module scaled_matrix_multiply_accumulate
	import smma_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	smma_in_if.sink               item,
	smma_out_if.source            result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	smma_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_func  (item.func),
		.item_ready (item.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	smma_datapath #(
		.MAX_DIM (MAX_DIM)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.item_func        (item.func),
		.item_index       (item.index),
		.item_value       (item.value),
		.cmd              (cmd),
		.sts              (sts),
		.result_valid     (result.valid),
		.result_ready     (result.ready),
		.result_value     (result.result_value),
		.result_saturated (result.saturated)
	);

endmodule

// ----- rtl/smma_checker.sv -----
`include "assert_macros.svh"

module smma_checker
	import smma_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input logic [1:0]        item_func,
	input logic signed [31:0] item_value,
	input logic              result_valid,
	input logic              result_ready,
	input logic signed [31:0] result_value,
	input logic              result_saturated
);

	// Hold a stalled result beat
	`SMMA_ASSERT_NXT(a_res_hold, result_valid && !result_ready, result_valid, "result beat dropped while stalled")
	`SMMA_ASSERT_NXT(a_res_stable, result_valid && !result_ready, $stable(result_value) && $stable(result_saturated), "result payload changed while stalled")

	// A load keeps the block busy for its result cycle
	`SMMA_ASSERT_NXT(a_busy_after_load, item_valid && item_ready && item_func != FUNC_COMPUTE, !item_ready, "item taken during load result cycle")

	// A C load into an empty output echoes its value, unsaturated, once the push state has loaded the output register
	`SMMA_ASSERT_IMP(a_cload_echo, item_valid && item_ready && item_func == FUNC_LOAD_C && !result_valid, ##2 (result_valid && !result_saturated && result_value == $past(item_value, 2)), "C load result wrong or late")

endmodule

bind scaled_matrix_multiply_accumulate smma_checker u_smma_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.item_valid       (item.valid),
	.item_ready       (item.ready),
	.item_func        (item.func),
	.item_value       (item.value),
	.result_valid     (result.valid),
	.result_ready     (result.ready),
	.result_value     (result.result_value),
	.result_saturated (result.saturated)
);
